FILE: design/fuzzy_cluster_head_score_top_defines.svh
// Assertion macros for the fuzzy cluster head score block.
`ifndef FUZZY_CLUSTER_HEAD_SCORE_TOP_DEFINES_SVH
`define FUZZY_CLUSTER_HEAD_SCORE_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define FCHS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define FCHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/fchs_pkg.sv
// Types, constants and helper functions for the fuzzy cluster head score block.
`default_nettype none

package fchs_pkg;

  localparam int DIV_STG = 4;
  localparam int NSTG    = 4 + DIV_STG;

  localparam logic [19:0] E_MED_A  = 20'd65536;
  localparam logic [19:0] E_MED_B  = 20'd163840;
  localparam logic [19:0] E_MED_C  = 20'd262144;
  localparam logic [19:0] E_HIGH_A = 20'd229376;
  localparam logic [19:0] E_HIGH_C = 20'd327680;

  localparam logic [14:0] C_LOW_B = 15'd7680;
  localparam logic [14:0] C_LOW_C = 15'd15360;

  localparam logic [18:0] RECIP3  = 19'd349526;
  localparam logic [20:0] RECIP15 = 21'd1118482;

  localparam logic [15:0] SCORE_MAX = 16'd58982;
  localparam logic [15:0] SCORE_MIN = 16'd45875;

  typedef struct packed {
    logic [20:0] rem;
    logic [15:0] q;
  } div_t;

  function automatic logic [16:0] med_deg(input logic [3:0] d);
    logic [16:0] m;
    case (d)
      4'd4:    m = 17'd32768;
      4'd5:    m = 17'd65536;
      4'd6:    m = 17'd43690;
      4'd7:    m = 17'd21845;
      default: m = 17'd0;
    endcase
    return m;
  endfunction

  function automatic logic [16:0] high_deg(input logic [3:0] d);
    logic [16:0] m;
    case (d)
      4'd7:    m = 17'd16384;
      4'd8:    m = 17'd32768;
      4'd9:    m = 17'd49152;
      default: m = 17'd0;
    endcase
    return m;
  endfunction

  function automatic logic [16:0] min3(input logic [16:0] p, input logic [16:0] q,
                                      input logic [16:0] r);
    logic [16:0] m;
    m = (p < q) ? p : q;
    return (m < r) ? m : r;
  endfunction

  // Four restoring steps of a fractional divide; rem stays below dv.
  function automatic div_t div_step4(input logic [20:0] rem, input logic [20:0] dv,
                                     input logic [15:0] q);
    logic [21:0] t;
    div_t        r;
    r.rem = rem;
    r.q   = q;
    for (int i = 0; i < 4; i++) begin
      t = {r.rem, 1'b0};
      if (t >= {1'b0, dv}) begin
        r.rem = 21'(t - {1'b0, dv});
        r.q   = {r.q[14:0], 1'b1};
      end else begin
        r.rem = t[20:0];
        r.q   = {r.q[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/fuzzy_cluster_head_score_top.sv
// Top level of the fuzzy cluster head score pipeline.
//
//   Channel  Ports                                                   Dir
//   in       in_valid in_ready in_energy_ratio in_neighbour_degree   in
//            in_centre_distance
//   out      out_valid out_ready out_head_score                      out
//
// Eight register stages: offsets, reciprocal multiplies, rule minimums,
// divide setup, then four stages of four quotient bits each.
// One word per cycle while out_ready does not stall the pipeline.
// Synchronous active-low reset clears only the stage valid bits.
// Each stage advances when empty or when the next stage advances, so a
// stall on out_ready backs up stage by stage without loss or repeat.
`default_nettype none

`include "fuzzy_cluster_head_score_top_defines.svh"

module fuzzy_cluster_head_score_top import fchs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_energy_ratio,
  input  wire logic [3:0]  in_neighbour_degree,
  input  wire logic [14:0] in_centre_distance,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_head_score
);

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  logic [19:0] ex;
  logic [16:0] me_t_nxt, he_t_nxt;
  logic [12:0] lc_t_nxt;

  logic [16:0] s1_me_t_r, s1_he_t_r;
  logic [12:0] s1_lc_t_r;
  logic [16:0] s1_md_r, s1_hd_r;

  logic [36:0] me_prod, he_prod;
  logic [33:0] lc_prod;

  logic [16:0] s2_me_r, s2_he_r, s2_lc_r, s2_md_r, s2_hd_r;
  logic [16:0] s3_r1_r, s3_r2_r, s3_r3_r;

  logic [17:0] den_nxt;
  logic [20:0] dv_nxt, num_nxt;

  logic [20:0] rem_r [0:DIV_STG-1];
  logic [20:0] dv_r  [0:DIV_STG-1];
  logic [15:0] q_r   [1:DIV_STG];

  // stage enables, from the output back to the input
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready       = en[0];
  assign out_valid      = v_r[NSTG-1];
  assign out_head_score = q_r[DIV_STG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: distances from the breakpoints
  assign ex = 20'(in_energy_ratio) * 20'd10;

  always_comb begin
    me_t_nxt = '0;
    if (ex > E_MED_A && ex < E_MED_C) begin
      me_t_nxt = (ex <= E_MED_B) ? 17'(ex - E_MED_A) : 17'(E_MED_C - ex);
    end
    he_t_nxt = '0;
    if (ex > E_HIGH_A && ex < E_HIGH_C) begin
      he_t_nxt = 17'(ex - E_HIGH_A);
    end
    lc_t_nxt = '0;
    if (in_centre_distance != '0 && in_centre_distance < C_LOW_C) begin
      lc_t_nxt = (in_centre_distance <= C_LOW_B) ? 13'(in_centre_distance)
                                                 : 13'(C_LOW_C - in_centre_distance);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_me_t_r <= me_t_nxt;
      s1_he_t_r <= he_t_nxt;
      s1_lc_t_r <= lc_t_nxt;
      s1_md_r   <= med_deg(in_neighbour_degree);
      s1_hd_r   <= high_deg(in_neighbour_degree);
    end
  end

  // stage 2: scale by 2/3 and 128/15 through reciprocals
  assign me_prod = 37'({s1_me_t_r, 1'b0}) * 37'(RECIP3);
  assign he_prod = 37'({s1_he_t_r, 1'b0}) * 37'(RECIP3);
  assign lc_prod = 34'(s1_lc_t_r) * 34'(RECIP15);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_me_r <= me_prod[36:20];
      s2_he_r <= he_prod[36:20];
      s2_lc_r <= lc_prod[33:17];
      s2_md_r <= s1_md_r;
      s2_hd_r <= s1_hd_r;
    end
  end

  // stage 3: rule strengths
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_r1_r <= min3(s2_he_r, s2_hd_r, s2_lc_r);
      s3_r2_r <= min3(s2_he_r, s2_md_r, s2_lc_r);
      s3_r3_r <= min3(s2_me_r, s2_hd_r, s2_lc_r);
    end
  end

  // stage 4: numerator 7*den + 2*r1 over 10*den; all-zero strengths divide 0 by 1
  assign den_nxt = 18'(s3_r1_r) + 18'(s3_r2_r) + 18'(s3_r3_r);
  assign dv_nxt  = (den_nxt == '0) ? 21'd1
                                   : 21'({den_nxt, 3'b000}) + 21'({den_nxt, 1'b0});
  assign num_nxt = 21'({den_nxt, 3'b000}) - 21'(den_nxt) + 21'({s3_r1_r, 1'b0});

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rem_r[0] <= num_nxt;
      dv_r[0]  <= dv_nxt;
    end
  end

  // stages 5 to 8: quotient bits
  for (genvar j = 1; j <= DIV_STG; j++) begin : g_div
    logic [15:0] q_in;
    div_t        dres;

    if (j == 1) begin : g_first
      assign q_in = '0;
    end else begin : g_rest
      assign q_in = q_r[j-1];
    end

    assign dres = div_step4(rem_r[j-1], dv_r[j-1], q_in);

    always_ff @(posedge clk) begin
      if (en[3+j]) begin
        q_r[j] <= dres.q;
      end
    end

    if (j < DIV_STG) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[3+j]) begin
          rem_r[j] <= dres.rem;
          dv_r[j]  <= dv_r[j-1];
        end
      end
    end
  end

  `FCHS_ASSERT_IMPLIES(a_score_max, out_valid, out_head_score <= SCORE_MAX, "score above 0.9")
  `FCHS_ASSERT_IMPLIES(a_score_min, out_valid && out_head_score != '0, out_head_score >= SCORE_MIN, "nonzero score below 0.7")
  `FCHS_ASSERT_IMPLIES(a_div_setup, v_r[3], rem_r[0] < dv_r[0], "dividend not below divisor")
  `FCHS_ASSERT_NEXT(a_stage_hold, v_r[NSTG-2] && !en[NSTG-1], v_r[NSTG-2], "stalled word dropped")

endmodule

`default_nettype wire

FILE: tb/fchs_score_checker.sv
// Scoreboard that predicts the cluster head score of each accepted word and checks the results.
module fchs_score_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [15:0]       in_energy_ratio,
  input  logic [3:0]        in_neighbour_degree,
  input  logic [14:0]       in_centre_distance,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [15:0]       out_head_score,
  output int unsigned       fail_count,
  output int unsigned       pending,
  output int unsigned       checked,
  output int unsigned       nonzero
);

  localparam logic [19:0] MU_ONE     = 20'd65536;
  localparam logic [19:0] EN_MED_LO  = 20'd65536;
  localparam logic [19:0] EN_MED_PK  = 20'd163840;
  localparam logic [19:0] EN_MED_HI  = 20'd262144;
  localparam logic [19:0] EN_HIGH_LO = 20'd229376;
  localparam logic [19:0] EN_HIGH_PK = 20'd327680;
  localparam logic [19:0] DG_MED_LO  = 20'd3;
  localparam logic [19:0] DG_MED_PK  = 20'd5;
  localparam logic [19:0] DG_MED_HI  = 20'd8;
  localparam logic [19:0] DG_HIGH_LO = 20'd6;
  localparam logic [19:0] DG_HIGH_PK = 20'd10;
  localparam logic [19:0] CD_NEAR_PK = 20'd7680;
  localparam logic [19:0] CD_NEAR_HI = 20'd15360;

  logic [15:0] expected_scores[$];

  function automatic logic [16:0] triangle_mu(input logic [19:0] x, input logic [19:0] a,
                                              input logic [19:0] b, input logic [19:0] c);
    logic [63:0] q;
    if (x <= a || x >= c)
      q = 64'd0;
    else if (x <= b)
      q = (b == a) ? 64'(MU_ONE) : (64'(x - a) << 16) / 64'(b - a);
    else
      q = (c == b) ? 64'(MU_ONE) : (64'(c - x) << 16) / 64'(c - b);
    return q[16:0];
  endfunction

  function automatic logic [16:0] min_of3(input logic [16:0] p, input logic [16:0] q,
                                          input logic [16:0] r);
    logic [16:0] m;
    m = (p < q) ? p : q;
    return (m < r) ? m : r;
  endfunction

  function automatic logic [15:0] head_score_of(input logic [15:0] energy,
                                                input logic [3:0] degree,
                                                input logic [14:0] distance);
    logic [19:0] ex;
    logic [16:0] med_e, high_e, med_d, high_d, near_c, r1, r2, r3;
    logic [63:0] weight_sum, strength_sum, q;
    ex     = 20'(energy) * 20'd10;
    med_e  = triangle_mu(ex, EN_MED_LO, EN_MED_PK, EN_MED_HI);
    high_e = triangle_mu(ex, EN_HIGH_LO, EN_HIGH_PK, EN_HIGH_PK);
    med_d  = triangle_mu(20'(degree), DG_MED_LO, DG_MED_PK, DG_MED_HI);
    high_d = triangle_mu(20'(degree), DG_HIGH_LO, DG_HIGH_PK, DG_HIGH_PK);
    near_c = triangle_mu(20'(distance), 20'd0, CD_NEAR_PK, CD_NEAR_HI);
    r1 = min_of3(high_e, high_d, near_c);
    r2 = min_of3(high_e, med_d, near_c);
    r3 = min_of3(med_e, high_d, near_c);
    strength_sum = 64'(r1) + 64'(r2) + 64'(r3);
    weight_sum   = 64'd9 * 64'(r1) + 64'd7 * 64'(r2) + 64'd7 * 64'(r3);
    if (strength_sum == 64'd0)
      q = 64'd0;
    else
      q = (weight_sum << 16) / (strength_sum * 64'd10);
    return q[15:0];
  endfunction

  always @(posedge clk) begin
    logic [15:0] exp_score;
    if (!rst_n) begin
      expected_scores.delete();
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      nonzero    = 0;
    end else begin
      if (in_valid && in_ready)
        expected_scores.push_back(head_score_of(in_energy_ratio, in_neighbour_degree,
                                                in_centre_distance));
      if (out_valid && out_ready) begin
        if (expected_scores.size() == 0) begin
          $display("%0t: head_score %0d arrived with no word pending", $time, out_head_score);
          fail_count++;
        end else begin
          exp_score = expected_scores.pop_front();
          checked++;
          if (exp_score != 16'd0)
            nonzero++;
          if (out_head_score !== exp_score) begin
            $display("%0t: head_score mismatch, expected %0d, got %0d",
                     $time, exp_score, out_head_score);
            fail_count++;
          end
        end
      end
      pending = expected_scores.size();
    end
  end

endmodule

FILE: tb/tb_fuzzy_cluster_head_score_top.sv
// Testbench top: drives node words into the score pipeline and reports the verdict.
module tb_fuzzy_cluster_head_score_top;

  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_TAIL  = 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_energy_ratio = '0;
  logic [3:0]  in_neighbour_degree = '0;
  logic [14:0] in_centre_distance = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_head_score;

  int unsigned fail_count, pending, checked, nonzero;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          words_sent = 0;
  int          quiet_cycles = 0;

  always #1 clk = ~clk;

  fuzzy_cluster_head_score_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_energy_ratio     (in_energy_ratio),
    .in_neighbour_degree (in_neighbour_degree),
    .in_centre_distance  (in_centre_distance),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_head_score      (out_head_score)
  );

  fchs_score_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_energy_ratio     (in_energy_ratio),
    .in_neighbour_degree (in_neighbour_degree),
    .in_centre_distance  (in_centre_distance),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_head_score      (out_head_score),
    .fail_count          (fail_count),
    .pending             (pending),
    .checked             (checked),
    .nonzero             (nonzero)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("fuzzy_cluster_head_score_top verification failed");
        $finish;
      end
    end
  end

  task automatic send_node(input logic [15:0] energy, input logic [3:0] degree,
                           input logic [14:0] distance);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_energy_ratio     <= energy;
    in_neighbour_degree <= degree;
    in_centre_distance  <= distance;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_nodes(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 70)
        send_node(16'($urandom_range(6554, 32767)), 4'($urandom_range(4, 9)),
                  15'($urandom_range(1, 15359)));
      else
        send_node(16'($urandom), 4'($urandom), 15'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct  = 9;
    recv_stall_pct = 52;
    send_node(16'd0,     4'd0,  15'd0);
    send_node(16'hFFFF,  4'hF,  15'h7FFF);
    send_node(16'd32768, 4'd9,  15'd100);
    send_node(16'd32767, 4'd9,  15'd7680);
    send_node(16'd22937, 4'd8,  15'd7680);
    send_node(16'd22938, 4'd8,  15'd7680);
    send_node(16'd16384, 4'd9,  15'd7680);
    send_node(16'd26214, 4'd5,  15'd7680);
    send_node(16'd6553,  4'd9,  15'd3000);
    send_node(16'd6554,  4'd9,  15'd3000);
    send_node(16'd30000, 4'd10, 15'd3000);
    send_node(16'd30000, 4'd15, 15'd3000);
    send_node(16'd30000, 4'd6,  15'd3000);
    send_node(16'd30000, 4'd7,  15'd3000);
    send_node(16'd30000, 4'd3,  15'd3000);
    send_node(16'd30000, 4'd4,  15'd3000);
    send_node(16'd30000, 4'd9,  15'd0);
    send_node(16'd30000, 4'd9,  15'd15360);
    send_node(16'd30000, 4'd9,  15'd15359);
    send_node(16'd30000, 4'd9,  15'd1);
    send_node(16'd24000, 4'd7,  15'd10000);
    send_node(16'd24000, 4'd7,  15'd5000);
    send_node(16'd65535, 4'd9,  15'd7680);
    send_node(16'd1,     4'd1,  15'h7FFF);

    send_random_nodes(142);
    send_idle_pct  = 52;
    recv_stall_pct = 9;
    send_random_nodes(142);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_nodes(142);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);

    $display("Sent %0d node words under receiver-heavy stalls, sender-heavy gaps and",
             words_sent);
    $display("full rate; %0d scores checked, %0d of them nonzero.", checked, nonzero);
    if (fail_count == 0) begin
      $display("fuzzy_cluster_head_score_top verification clean");
    end else begin
      $display("fuzzy_cluster_head_score_top verification failed");
    end
    $finish;
  end

endmodule
